/* sv/spectrum_rms_level_meter_defines.svh */
// Assertion macros shared by the spectrum rms level meter checkers.
// Depends on nothing; included by the files that hold assertions.
`ifndef SPECTRUM_RMS_LEVEL_METER_DEFINES_SVH
`define SPECTRUM_RMS_LEVEL_METER_DEFINES_SVH

// The consequent must hold in the clock after the antecedent.
`define SRLM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("srlm assertion failed");

// The consequent must hold in the same clock as the antecedent.
`define SRLM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("srlm assertion failed");

`endif

/* sv/srlm_pkg.sv */
// Package for the spectrum rms level meter: sequencer states and register indexes.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package srlm_pkg;

    localparam int CFG_INDEX_W = 1;

    localparam logic [CFG_INDEX_W-1:0] CFG_RMS_OFFSET      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SMOOTHING_ALPHA = 1'd1;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_SQ_RE   = 10'b00_0000_0010,
        S_SQ_IM   = 10'b00_0000_0100,
        S_ACCUM   = 10'b00_0000_1000,
        S_ROOT    = 10'b00_0001_0000,
        S_VALUE   = 10'b00_0010_0000,
        S_MUL_LO  = 10'b00_0100_0000,
        S_MUL_HI  = 10'b00_1000_0000,
        S_MUL_VAL = 10'b01_0000_0000,
        S_FINISH  = 10'b10_0000_0000
    } t_state;

endpackage

`default_nettype wire

/* sv/spectrum_rms_level_meter.sv */
// Spectrum rms level meter: Parseval power sum, square root and time weighting.
// Depends on srlm_pkg; one shared 18 by 18 signed multiplier under a sequencer.
//
// Bins enter on the s_axis channel, bin 0 first, one transaction per bin, with
// s_axis_tlast marking the last bin of the frame. Each bin is squared and summed
// in two multiplier passes plus one accumulate step, and s_axis_tready stays low
// from each transaction until that bin has been summed into the power sum.
// The last bin then runs a digit-by-digit square root, one step to add the
// offset and three multiplier passes for the smoothing, and then the level
// appears on m_axis; the next bin can be taken in that same cycle. The shared
// multiplier paces the bins and the root iteration paces the end of each frame.
// The result sits in an output register; while the receiver stalls, the block
// still takes bins and only holds in its final step until the register frees.
// The cfg channel is always ready and must be written only while the block idles.
// Synchronous reset clears the power sum, the level, both registers and the
// output valid flag.
`default_nettype none

module spectrum_rms_level_meter
    import srlm_pkg::*;
#(
    parameter int LOG2_POINTS = 6
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire  [31:0]            s_axis_tdata,   // bin_real[15:0], bin_imag[31:16]
    input  wire                    s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    output logic [15:0]            m_axis_tdata,   // level[14:0], zero[15]
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire  [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire  [15:0]            i_cfg_data
);

    localparam int SHIFT = 2 * LOG2_POINTS;

    t_state              r_state, n_state;
    logic [15:0]         r_offset, n_offset;
    logic [15:0]         r_alpha, n_alpha;
    logic [15:0]         r_sum, n_sum;
    logic [30:0]         r_level, n_level;
    logic                r_out_valid, n_out_valid;
    logic [14:0]         r_out_level, n_out_level;
    logic [16:0]         r_re_abs, n_re_abs;
    logic [16:0]         r_im_abs, n_im_abs;
    logic                r_last, n_last;
    logic signed [35:0]  r_acc, n_acc;
    logic [15:0]         r_rad, n_rad;
    logic [11:0]         r_rem, n_rem;
    logic [7:0]          r_root, n_root;
    logic [2:0]          r_cnt, n_cnt;
    logic signed [15:0]  r_value, n_value;

    logic signed [17:0]  w_mul_a, w_mul_b;
    logic signed [35:0]  w_prod;
    logic [31:0]         w_shifted;
    logic [15:0]         w_sum_add;
    logic [11:0]         w_rem_sh;
    logic [11:0]         w_trial;
    logic signed [16:0]  w_val_sum;
    logic [16:0]         w_one_minus;
    logic                w_in_accept;

    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_level};

    assign w_one_minus = 17'h10000 - {1'b0, r_alpha};
    assign w_shifted   = r_acc[31:0] >> SHIFT;
    assign w_sum_add   = r_sum + w_shifted[15:0];
    assign w_rem_sh    = {r_rem[9:0], r_rad[15:14]};
    assign w_trial     = {2'b00, r_root, 2'b01};
    assign w_val_sum   = $signed({9'b0, r_root}) + $signed({r_offset[15], r_offset});
    assign w_prod      = w_mul_a * w_mul_b;

    always_comb begin
        w_mul_a = {1'b0, r_re_abs};
        w_mul_b = {1'b0, r_re_abs};
        case (r_state)
            S_SQ_IM: begin
                w_mul_a = {1'b0, r_im_abs};
                w_mul_b = {1'b0, r_im_abs};
            end
            S_MUL_LO: begin
                w_mul_a = {2'b00, r_alpha};
                w_mul_b = {2'b00, r_level[15:0]};
            end
            S_MUL_HI: begin
                w_mul_a = {2'b00, r_alpha};
                w_mul_b = {3'b000, r_level[30:16]};
            end
            S_MUL_VAL: begin
                w_mul_a = {1'b0, w_one_minus};
                w_mul_b = {{2{r_value[15]}}, r_value};
            end
            default: begin
                w_mul_a = {1'b0, r_re_abs};
                w_mul_b = {1'b0, r_re_abs};
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_offset    = r_offset;
        n_alpha     = r_alpha;
        n_sum       = r_sum;
        n_level     = r_level;
        n_out_valid = r_out_valid;
        n_out_level = r_out_level;
        n_re_abs    = r_re_abs;
        n_im_abs    = r_im_abs;
        n_last      = r_last;
        n_acc       = r_acc;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_cnt       = r_cnt;
        n_value     = r_value;

        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_RMS_OFFSET) begin
                n_offset = i_cfg_data;
            end else if (i_cfg_index == CFG_SMOOTHING_ALPHA) begin
                n_alpha = i_cfg_data;
            end
        end

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    n_re_abs = s_axis_tdata[15] ? 17'h10000 - {1'b0, s_axis_tdata[15:0]}
                                                : {1'b0, s_axis_tdata[15:0]};
                    n_im_abs = s_axis_tdata[31] ? 17'h10000 - {1'b0, s_axis_tdata[31:16]}
                                                : {1'b0, s_axis_tdata[31:16]};
                    n_last   = s_axis_tlast;
                    n_state  = S_SQ_RE;
                end
            end
            S_SQ_RE: begin
                n_acc   = w_prod;
                n_state = S_SQ_IM;
            end
            S_SQ_IM: begin
                n_acc   = r_acc + w_prod;
                n_state = S_ACCUM;
            end
            S_ACCUM: begin
                if (r_last) begin
                    n_rad   = {w_sum_add[14:0], 1'b0};
                    n_sum   = 16'd0;
                    n_rem   = 12'd0;
                    n_root  = 8'd0;
                    n_cnt   = 3'd0;
                    n_state = S_ROOT;
                end else begin
                    n_sum   = w_sum_add;
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                if (w_rem_sh >= w_trial) begin
                    n_rem  = w_rem_sh - w_trial;
                    n_root = {r_root[6:0], 1'b1};
                end else begin
                    n_rem  = w_rem_sh;
                    n_root = {r_root[6:0], 1'b0};
                end
                n_rad = {r_rad[13:0], 2'b00};
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = S_VALUE;
                end
            end
            S_VALUE: begin
                if (w_val_sum > 17'sd32767) begin
                    n_value = 16'sd32767;
                end else begin
                    n_value = w_val_sum[15:0];
                end
                n_state = S_MUL_LO;
            end
            S_MUL_LO: begin
                n_acc   = w_prod;
                n_state = S_MUL_HI;
            end
            S_MUL_HI: begin
                n_acc   = (r_acc >>> 16) + w_prod;
                n_state = S_MUL_VAL;
            end
            S_MUL_VAL: begin
                n_acc   = r_acc + w_prod;
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_level     = r_acc[35] ? 31'd0 : r_acc[30:0];
                    n_out_level = r_acc[35] ? 15'd0 : r_acc[30:16];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= 16'd0;
            r_alpha     <= 16'd0;
            r_sum       <= 16'd0;
            r_level     <= 31'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_offset    <= n_offset;
            r_alpha     <= n_alpha;
            r_sum       <= n_sum;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_level <= n_out_level;
        r_re_abs    <= n_re_abs;
        r_im_abs    <= n_im_abs;
        r_last      <= n_last;
        r_acc       <= n_acc;
        r_rad       <= n_rad;
        r_rem       <= n_rem;
        r_root      <= n_root;
        r_cnt       <= n_cnt;
        r_value     <= n_value;
    end

endmodule

`default_nettype wire

/* sv/srlm_checker.sv */
// Port-level checker for the spectrum rms level meter, bound to the top level.
// Depends on srlm_pkg and the assertion macros in the defines header.
`include "spectrum_rms_level_meter_defines.svh"
`default_nettype none

module srlm_checker
    import srlm_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   s_axis_tvalid,
    input wire                   s_axis_tready,
    input wire [31:0]            s_axis_tdata,   // bin_real[15:0], bin_imag[31:16]
    input wire                   s_axis_tlast,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [15:0]            m_axis_tdata,   // level[14:0], zero[15]
    input wire                   i_cfg_valid,
    input wire                   o_cfg_ready,
    input wire [CFG_INDEX_W-1:0] i_cfg_index,
    input wire [15:0]            i_cfg_data
);

    `SRLM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `SRLM_ASSERT_NEXT(a_reset_clears, i_clk, 1'b1, !i_rst_n, !m_axis_tvalid)
    `SRLM_ASSERT_NEXT(a_busy_after_bin, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SRLM_ASSERT_SAME(a_level_range, i_clk, i_rst_n, m_axis_tvalid, !m_axis_tdata[15])

endmodule

bind spectrum_rms_level_meter srlm_checker u_srlm_checker (.*);

`default_nettype wire

/* verif/tb_top.sv */
// Self-checking testbench for spectrum_rms_level_meter: streams FFT bins in framed bursts,
// predicts each smoothed level and compares it with the m_axis transactions.
// Depends on srlm_pkg and the spectrum_rms_level_meter RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srlm_pkg::*;

    localparam int LOG2_POINTS = 6;
    localparam int FRAME_BINS = (1 << LOG2_POINTS) / 2 + 1;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
    } t_bin;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [31:0]            s_axis_tdata = '0;  // bin_real[15:0], bin_imag[31:16]
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [15:0]            m_axis_tdata;       // level[14:0], zero[15]
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = CFG_RMS_OFFSET;
    logic [15:0]            i_cfg_data = '0;

    spectrum_rms_level_meter #(
        .LOG2_POINTS(LOG2_POINTS)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_bin        pending_bins[$];
    logic [14:0] expected_levels[$];

    logic signed [15:0] cur_offset = '0;
    logic [15:0]        cur_alpha = '0;
    logic [15:0]        power_sum_model = '0;
    int                 weighted_level = 0;

    logic bin_taken = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   rx_mode = 0;
    int   rx_left = 0;
    int   fail_count = 0;
    int   bins_sent = 0;
    int   levels_checked = 0;
    int   settings_used = 0;

    // Folds one accepted bin into the power sum; a last bin closes the frame and
    // yields the next smoothed level.
    function automatic void fold_bin(logic [15:0] re_raw, logic [15:0] im_raw, logic last);
        logic [16:0] re_mag;
        logic [16:0] im_mag;
        logic [31:0] power;
        logic [15:0] doubled;
        int          root;
        int          value;
        longint      acc;
        re_mag = re_raw[15] ? 17'h10000 - {1'b0, re_raw} : {1'b0, re_raw};
        im_mag = im_raw[15] ? 17'h10000 - {1'b0, im_raw} : {1'b0, im_raw};
        power = 32'(re_mag) * 32'(re_mag) + 32'(im_mag) * 32'(im_mag);
        power_sum_model = power_sum_model + 16'(power >> (2 * LOG2_POINTS));
        if (last) begin
            doubled = {power_sum_model[14:0], 1'b0};
            root = 0;
            for (int r = 1; r < 256; r++) begin
                if (r * r <= int'(doubled)) root = r;
            end
            value = root + int'(cur_offset);
            if (value > 32767) value = 32767;
            acc = longint'(cur_alpha) * longint'(weighted_level)
                + (65536 - longint'(cur_alpha)) * (longint'(value) * 65536);
            weighted_level = (acc < 0) ? 0 : int'(acc / 65536);
            power_sum_model = '0;
            expected_levels.push_back(weighted_level[30:16]);
        end
    endfunction

    always @(posedge i_clk) begin
        logic [14:0] want;
        bin_taken <= s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_levels.size() == 0) begin
                    $error("level: unexpected transaction, actual %0d", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = expected_levels.pop_front();
                    if (m_axis_tdata !== {1'b0, want}) begin
                        $error("level mismatch: expected %0d, actual %0d", want, m_axis_tdata);
                        fail_count++;
                    end
                    levels_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                fold_bin(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
                bins_sent++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RMS_OFFSET:      cur_offset = i_cfg_data;
                    CFG_SMOOTHING_ALPHA: cur_alpha = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always @(negedge i_clk) begin
        t_bin nxt;
        logic drive_valid;
        drive_valid = 1'b0;
        if (!i_rst_n) begin
            drive_valid = 1'b0;
        end else if (s_axis_tvalid && !bin_taken) begin
            drive_valid = 1'b1;
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
        end else if (pending_bins.size() > 0) begin
            nxt = pending_bins.pop_front();
            s_axis_tdata <= {nxt.im, nxt.re};
            s_axis_tlast <= nxt.last;
            drive_valid = 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 40);
                gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
        s_axis_tvalid <= drive_valid;
    end

    always @(negedge i_clk) begin
        logic rdy;
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 2);
            rx_left <= $urandom_range(20, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = ($urandom_range(0, 3) != 0);
            default: rdy = ($urandom_range(0, 7) == 0);
        endcase
        m_axis_tready <= rdy;
    end

    task automatic push_bin(logic [15:0] re, logic [15:0] im, logic last);
        t_bin b;
        b.re = re;
        b.im = im;
        b.last = last;
        pending_bins.push_back(b);
    endtask

    function automatic logic [15:0] pick_part(int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8000) - 4000);
            2: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7fff;
                    2:       return 16'h0000;
                    3:       return 16'hffff;
                    default: return 16'h0001;
                endcase
            end
            default: return 16'($urandom_range(0, 600) - 300);
        endcase
    endfunction

    task automatic push_frame(int len);
        int style;
        style = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            push_bin(pick_part(style), pick_part(style), i == len - 1);
        end
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(logic [15:0] offset, logic [15:0] alpha);
        write_reg(CFG_RMS_OFFSET, offset);
        write_reg(CFG_SMOOTHING_ALPHA, alpha);
        settings_used++;
    endtask

    // A non-last bin may still be in the sequencer when the last level has come.
    task automatic drain();
        while (pending_bins.size() != 0 || s_axis_tvalid || expected_levels.size() != 0)
            @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] offset;
        logic [15:0] alpha;
        int          len;
        int          phase_bins;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        push_bin(16'h8000, 16'h8000, 1'b1);
        push_bin(16'h7fff, 16'h7fff, 1'b0);
        push_bin(16'h7fff, 16'h8000, 1'b0);
        push_bin(16'h0000, 16'h0000, 1'b1);
        push_bin(16'h0001, 16'hffff, 1'b1);
        push_bin(16'h8000, 16'h0000, 1'b0);
        push_bin(16'h0000, 16'h7fff, 1'b1);
        drain();

        set_registers(16'h7fff, 16'h0000);
        push_bin(16'h7fff, 16'h8000, 1'b1);
        push_bin(16'd20000, 16'd5000, 1'b1);
        drain();

        set_registers(16'h8000, 16'h0000);
        push_bin(16'd100, 16'd100, 1'b1);
        push_bin(16'h7fff, 16'h7fff, 1'b1);
        drain();

        set_registers(16'd200, 16'hffff);
        push_bin(16'd1000, 16'hfc18, 1'b1);
        push_bin(16'h8000, 16'h7fff, 1'b1);
        push_bin(16'd30000, 16'd0, 1'b1);
        drain();

        set_registers(16'hffce, 16'h8000);
        push_bin(16'd5000, 16'hec78, 1'b0);
        push_bin(16'd12000, 16'd3000, 1'b1);
        drain();

        for (int phase = 0; phase < 8; phase++) begin
            case ($urandom_range(0, 3))
                0:       offset = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                1:       offset = 16'($urandom);
                default: offset = 16'($urandom_range(0, 600) - 300);
            endcase
            case ($urandom_range(0, 3))
                0:       alpha = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
                1:       alpha = 16'($urandom);
                default: alpha = 16'($urandom_range(49152, 65535));
            endcase
            set_registers(offset, alpha);
            phase_bins = 0;
            while (phase_bins < 160) begin
                case ($urandom_range(0, 9))
                    0:       len = $urandom_range(9, 40);
                    1, 2, 3,
                    4:       len = FRAME_BINS;
                    default: len = $urandom_range(1, 8);
                endcase
                push_frame(len);
                phase_bins += len;
            end
            drain();
        end

        $display("Sent %0d bins and checked %0d levels over %0d register settings,",
                 bins_sent, levels_checked, settings_used);
        $display("including saturated offsets, clamped levels and random frame lengths.");
        if (fail_count == 0) begin
            $display("spectrum_rms_level_meter verification clean");
        end else begin
            $display("spectrum_rms_level_meter verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("spectrum_rms_level_meter verification failed");
        $finish;
    end

endmodule
